/* rtl/lphm_pkg.sv */
// ----------------------------------------------------------------------------
// lphm_pkg: shared types and constants of the linear probing hash map
// Slot geometry, hash constant, opcodes and the beat types of both channels.
// ----------------------------------------------------------------------------
package lphm_pkg;

  // Table geometry (slot count is a power of two, home slot is a mask)
  localparam int SLOTS  = 1024;
  localparam int SLOT_W = 10;
  localparam int COUNT_W = 11;

  // Multiplicative hash; only its low bits reach the home slot
  localparam logic [63:0] HASH_MULT = 64'd2654435761;
  localparam logic [SLOT_W-1:0] HASH_LOW = HASH_MULT[SLOT_W-1:0];

  // Load limit after reset
  localparam logic [COUNT_W-1:0] LIMIT_RESET = 11'd768;

  // Register addresses
  localparam logic [1:0] ADDR_LIMIT = 2'd0;

  // Opcodes
  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  // Status codes
  localparam logic STAT_DONE = 1'b0;
  localparam logic STAT_FULL = 1'b1;

  // Slot word: used flag, key, value
  localparam int ENTRY_W = 129;

  // Command beat
  typedef struct packed {
    logic [1:0]        opcode;
    logic signed [63:0] key;
    logic signed [63:0] new_value;
    logic [SLOT_W-1:0] slot_index;
  } cmd_t;

  // Result beat
  typedef struct packed {
    logic               found;
    logic signed [63:0] value_out;
    logic signed [63:0] key_out;
    logic [COUNT_W-1:0] entry_count;
    logic               status;
  } rsp_t;

  // Queue entry: classified command with its first probe address
  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [63:0] key;
    logic signed [63:0] new_value;
    logic [SLOT_W-1:0]  addr;
  } job_t;

endpackage

/* rtl/lphm_ram.sv */
// ----------------------------------------------------------------------------
// lphm_ram: generic simple dual port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module lphm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/lphm_front.sv */
// ----------------------------------------------------------------------------
// lphm_front: command intake and classification
// Turns a command beat into a job with its first probe slot.
// ----------------------------------------------------------------------------
module lphm_front (
  input  lphm_pkg::cmd_t cmd,
  output lphm_pkg::job_t job
);

  logic [2*lphm_pkg::SLOT_W-1:0] prod;

  // Home slot: low bits of key times the hash constant
  assign prod = cmd.key[lphm_pkg::SLOT_W-1:0] * lphm_pkg::HASH_LOW;

  // Slot reads start at the given index, key ops at the home slot
  always_comb begin
    job.opcode    = cmd.opcode;
    job.key       = cmd.key;
    job.new_value = cmd.new_value;
    if (cmd.opcode == lphm_pkg::OP_READ) begin
      job.addr = cmd.slot_index;
    end else begin
      job.addr = prod[lphm_pkg::SLOT_W-1:0];
    end
  end

endmodule

/* rtl/lphm_fifo.sv */
// ----------------------------------------------------------------------------
// lphm_fifo: two-entry job queue
// Decouples command intake from the probe engine.
// ----------------------------------------------------------------------------
module lphm_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lphm_pkg::job_t push_job,
  input  logic           pop,
  output lphm_pkg::job_t pop_job,
  output logic           empty,
  output logic           full
);

  lphm_pkg::job_t slots [2];
  logic           wptr;
  logic           rptr;
  logic [1:0]     count;

  assign empty   = (count == 2'd0);
  assign full    = (count == 2'd2);
  assign pop_job = slots[rptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_job;
    end
  end

endmodule

/* rtl/lphm_back.sv */
// ----------------------------------------------------------------------------
// lphm_back: probe engine
// Clears the occupancy after reset, then walks the slot RAM for each job
// and issues one result beat per job.
// ----------------------------------------------------------------------------
module lphm_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            job_valid,
  input  lphm_pkg::job_t                  job,
  output logic                            job_pop,
  input  logic [lphm_pkg::COUNT_W-1:0]    entry_limit,
  output logic                            clearing,
  output logic                            done,
  output lphm_pkg::rsp_t                  rsp
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_ISSUE = 2'd2;
  localparam logic [1:0] ST_CHECK = 2'd3;
  localparam logic [lphm_pkg::SLOT_W-1:0] LAST_SLOT = lphm_pkg::SLOT_W'(lphm_pkg::SLOTS - 1);

  logic [1:0]                      state;
  logic [1:0]                      state_next;
  logic [lphm_pkg::SLOT_W-1:0]     addr;
  logic [lphm_pkg::SLOT_W-1:0]     probes;
  logic [1:0]                      op;
  logic signed [63:0]              key;
  logic signed [63:0]              val;
  logic [lphm_pkg::COUNT_W-1:0]    count;
  logic [lphm_pkg::COUNT_W-1:0]    count_next;

  logic                            we;
  logic [lphm_pkg::ENTRY_W-1:0]    wdata;
  logic [lphm_pkg::ENTRY_W-1:0]    rdata;
  logic                            used;
  logic signed [63:0]              rkey;
  logic signed [63:0]              rval;
  logic                            match;
  logic                            finish;
  lphm_pkg::rsp_t                  rsp_next;

  lphm_ram #(
    .WIDTH(lphm_pkg::ENTRY_W),
    .DEPTH(lphm_pkg::SLOTS)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(addr),
    .wdata(wdata),
    .raddr(addr),
    .rdata(rdata)
  );

  assign used     = rdata[lphm_pkg::ENTRY_W-1];
  assign rkey     = rdata[127:64];
  assign rval     = rdata[63:0];
  assign match    = used && (rkey == key);
  assign clearing = (state == ST_CLEAR);
  assign job_pop  = (state == ST_IDLE) && job_valid;

  // Decide the outcome of the slot just read
  always_comb begin
    we         = 1'b0;
    wdata      = {1'b1, key, val};
    finish     = 1'b0;
    count_next = count;
    rsp_next   = '0;
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        we    = 1'b1;
        wdata = '0;
        if (addr == LAST_SLOT) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (job_valid) begin
          state_next = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        case (op)
          lphm_pkg::OP_LOOKUP: begin
            if (!used || match || probes == LAST_SLOT) begin
              finish             = 1'b1;
              rsp_next.found     = match;
              rsp_next.value_out = match ? rval : 64'sd0;
            end
          end
          lphm_pkg::OP_INSERT: begin
            if (match) begin
              finish             = 1'b1;
              we                 = 1'b1;
              rsp_next.found     = 1'b1;
              rsp_next.value_out = val;
            end else if (!used && count < entry_limit) begin
              finish             = 1'b1;
              we                 = 1'b1;
              count_next         = count + 1'b1;
              rsp_next.value_out = val;
            end else if (!used || probes == LAST_SLOT) begin
              finish          = 1'b1;
              rsp_next.status = lphm_pkg::STAT_FULL;
            end
          end
          lphm_pkg::OP_READ: begin
            finish             = 1'b1;
            rsp_next.found     = used;
            rsp_next.value_out = used ? rval : 64'sd0;
            rsp_next.key_out   = used ? rkey : 64'sd0;
          end
          default: begin
            finish = 1'b1;
          end
        endcase
        state_next = finish ? ST_IDLE : ST_ISSUE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    rsp_next.entry_count = count_next;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_CLEAR;
      addr   <= '0;
      probes <= '0;
      count  <= '0;
      done   <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= (state == ST_CHECK) && finish;
      if (state == ST_CLEAR) begin
        addr <= addr + 1'b1;
      end else if (job_pop) begin
        addr   <= job.addr;
        probes <= '0;
      end else if (state == ST_CHECK && !finish) begin
        addr   <= addr + 1'b1;
        probes <= probes + 1'b1;
      end
    end
  end

  // Job payload and result beat
  always_ff @(posedge clk) begin
    if (job_pop) begin
      op  <= job.opcode;
      key <= job.key;
      val <= job.new_value;
    end
    if (state == ST_CHECK && finish) begin
      rsp <= rsp_next;
    end
  end

endmodule

/* rtl/linear_probe_hash_map.sv */
// ----------------------------------------------------------------------------
// linear_probe_hash_map: open addressing map, 64-bit keys to 64-bit values
// Linear probing over a 1024-slot RAM, load limit register on an APB port.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  command   start && !busy         cmd (cmd_t)
//  result    done, one cycle        rsp (rsp_t)
//  config    psel&penable&pwrite    paddr, pwdata, prdata
//
// Each job passes a dispatch state, then an issue state and a check state for
// each slot probed, set by the registered read of the slot RAM. A probe ends at
// a match, at an empty slot or after all 1024 slots; slot reads probe one slot.
// After reset all 1024 slots are cleared while busy is high.
// A two-entry job queue lets commands arrive while a probe runs.
// The receiver cannot stall; each result is on rsp for the cycle done is high.
// ----------------------------------------------------------------------------
module linear_probe_hash_map (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  lphm_pkg::cmd_t       cmd,
  output logic                 done,
  output lphm_pkg::rsp_t       rsp,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [1:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  logic [lphm_pkg::COUNT_W-1:0] entry_limit;
  lphm_pkg::job_t               front_job;
  lphm_pkg::job_t               queue_job;
  logic                         push;
  logic                         pop;
  logic                         empty;
  logic                         full;
  logic                         clearing;

  // Register port
  assign pready = 1'b1;
  assign prdata = (paddr == lphm_pkg::ADDR_LIMIT) ? {21'd0, entry_limit} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_limit <= lphm_pkg::LIMIT_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr == lphm_pkg::ADDR_LIMIT) begin
      entry_limit <= pwdata[lphm_pkg::COUNT_W-1:0];
    end
  end

  // Command intake
  assign busy = full || clearing;
  assign push = start && !busy;

  lphm_front u_front (
    .cmd(cmd),
    .job(front_job)
  );

  lphm_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_job(front_job),
    .pop     (pop),
    .pop_job (queue_job),
    .empty   (empty),
    .full    (full)
  );

  lphm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .job_valid  (!empty),
    .job        (queue_job),
    .job_pop    (pop),
    .entry_limit(entry_limit),
    .clearing   (clearing),
    .done       (done),
    .rsp        (rsp)
  );

endmodule

/* dv/lphm_checker.sv */
// ----------------------------------------------------------------------------
// lphm_checker: result predictor and scoreboard for the hash map
// Tracks command and config beats, models the probe table, and compares
// every result beat against the oldest predicted result.
// ----------------------------------------------------------------------------
module lphm_checker (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            busy,
  input  lphm_pkg::cmd_t  cmd,
  input  logic            done,
  input  lphm_pkg::rsp_t  rsp,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [1:0]      paddr,
  input  logic [31:0]     pwdata,
  input  logic            pready,
  output int              errors,
  output int              pending
);
  import lphm_pkg::*;

  logic [63:0]        tbl_key [SLOTS];
  logic [63:0]        tbl_val [SLOTS];
  logic               tbl_used [SLOTS];
  logic [COUNT_W-1:0] n_keys;
  logic [COUNT_W-1:0] load_limit;
  rsp_t               rsp_fifo [$];

  // Print one mismatch line and count it.
  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("checker: %s mismatch got %h want %h", what, got, want);
    errors++;
  endtask

  // Apply one command to the table copy and return the predicted result.
  function automatic rsp_t apply_cmd(input cmd_t c);
    rsp_t r;
    logic [63:0] h;
    logic [SLOT_W-1:0] idx;
    logic hit;
    int n;
    r = '0;
    hit = 1'b0;
    h = c.key * HASH_MULT;
    idx = h[SLOT_W-1:0];
    if (c.opcode == OP_LOOKUP || c.opcode == OP_INSERT) begin
      for (n = 0; n < SLOTS && !hit; n++) begin
        if (!tbl_used[idx] || tbl_key[idx] == c.key) hit = 1'b1;
        else idx = idx + 1'b1;
      end
    end
    if (c.opcode == OP_LOOKUP) begin
      if (hit && tbl_used[idx]) begin
        r.found = 1'b1;
        r.value_out = tbl_val[idx];
      end
    end else if (c.opcode == OP_INSERT) begin
      if (hit && tbl_used[idx]) begin
        r.found = 1'b1;
        tbl_val[idx] = c.new_value;
        r.value_out = c.new_value;
      end else if (hit && n_keys < load_limit) begin
        tbl_key[idx] = c.key;
        tbl_val[idx] = c.new_value;
        tbl_used[idx] = 1'b1;
        n_keys = n_keys + 1'b1;
        r.value_out = c.new_value;
      end else begin
        r.status = STAT_FULL;
      end
    end else if (c.opcode == OP_READ) begin
      if (tbl_used[c.slot_index]) begin
        r.found = 1'b1;
        r.value_out = tbl_val[c.slot_index];
        r.key_out = tbl_key[c.slot_index];
      end
    end
    r.entry_count = n_keys;
    return r;
  endfunction

  // Watch all three channels at the rising edge.
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) tbl_used[i] = 1'b0;
      n_keys = '0;
      load_limit = LIMIT_RESET;
      rsp_fifo.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == ADDR_LIMIT)
        load_limit = pwdata[COUNT_W-1:0];
      if (done) begin
        if (rsp_fifo.size() == 0) begin
          report("unexpected beat", rsp.value_out, 64'd0);
        end else begin
          want = rsp_fifo.pop_front();
          if (rsp.found !== want.found)
            report("found", 64'(rsp.found), 64'(want.found));
          if (rsp.value_out !== want.value_out)
            report("value_out", rsp.value_out, want.value_out);
          if (rsp.key_out !== want.key_out) report("key_out", rsp.key_out, want.key_out);
          if (rsp.entry_count !== want.entry_count)
            report("entry_count", 64'(rsp.entry_count), 64'(want.entry_count));
          if (rsp.status !== want.status)
            report("status", 64'(rsp.status), 64'(want.status));
        end
      end
      if (start && !busy) rsp_fifo.push_back(apply_cmd(cmd));
    end
    pending = rsp_fifo.size();
  end

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the linear probing hash map
// Drives directed and random command beats under several load limits with
// random sender gaps; the checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb;
  import lphm_pkg::*;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  cmd_t        cmd;
  logic        done;
  rsp_t        rsp;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          errors;
  int          pending;
  int          cycles;
  int          gap_pct;
  logic [63:0] key_pool [16];

  localparam int CYCLE_LIMIT = 2_000_000;

  // Opcode with no operation behind it
  localparam logic [1:0] OP_SPARE = 2'd3;

  linear_probe_hash_map u_top (.*);

  lphm_checker u_chk (.*);

  // Clock.
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Run-time guard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // Send one command beat, with an optional random gap first. start stays
  // high after the beat so that back-to-back beats need no second drive.
  task automatic send(input logic [1:0] op, input logic [63:0] k, input logic [63:0] v,
                      input logic [SLOT_W-1:0] s);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    cmd.opcode <= op;
    cmd.key <= k;
    cmd.new_value <= v;
    cmd.slot_index <= s;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop start, wait for all results, then drain before a register write.
  task automatic settle();
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (2100) @(negedge clk);
  endtask

  task automatic write_limit(input logic [COUNT_W-1:0] lim);
    settle();
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= ADDR_LIMIT;
    pwdata <= {21'd0, lim};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Mostly inserts and lookups on a small key pool, with reads and noise.
  task automatic random_phase(input int count);
    int r;
    logic [63:0] k;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      k = ($urandom_range(3) == 0) ? {$urandom, $urandom} : key_pool[$urandom_range(15)]
          + 64'($urandom_range(300));
      if (r < 40) send(OP_INSERT, k, {$urandom, $urandom}, SLOT_W'($urandom));
      else if (r < 75) send(OP_LOOKUP, k, {$urandom, $urandom}, SLOT_W'($urandom));
      else if (r < 95) send(OP_READ, {$urandom, $urandom}, {$urandom, $urandom},
                            SLOT_W'($urandom));
      else send(OP_SPARE, k, {$urandom, $urandom}, SLOT_W'($urandom));
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    cmd = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    gap_pct = 0;
    for (int i = 0; i < 16; i++) key_pool[i] = {$urandom, $urandom};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: extremes, every opcode, update at limit, refused insert.
    write_limit(11'd2);
    send(OP_READ, 64'd0, 64'd0, 10'd0);
    send(OP_LOOKUP, 64'h8000_0000_0000_0000, 64'd0, 10'd0);
    send(OP_INSERT, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 10'd0);
    send(OP_INSERT, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 10'd0);
    send(OP_INSERT, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 10'd0);
    send(OP_INSERT, 64'h7FFF_FFFF_FFFF_FFFF, 64'd5, 10'd0);
    send(OP_LOOKUP, 64'h7FFF_FFFF_FFFF_FFFF, 64'd0, 10'd0);
    send(OP_LOOKUP, 64'h8000_0000_0000_0000, 64'd0, 10'd0);
    send(OP_SPARE, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 10'h3FF);
    for (int s = 0; s < 1024; s += 128) send(OP_READ, 64'd0, 64'd0, SLOT_W'(s));
    send(OP_READ, 64'd0, 64'd0, 10'h3FF);
    write_limit(11'd0);
    send(OP_INSERT, 64'd1, 64'd1, 10'd0);
    send(OP_INSERT, 64'h8000_0000_0000_0000, 64'd9, 10'd0);

    // Random phases over several limits, with three idling profiles.
    write_limit(11'd40);
    gap_pct = 31;
    random_phase(300);
    write_limit(11'd1024);
    gap_pct = 53;
    random_phase(300);
    write_limit(11'd20);
    gap_pct = 0;
    random_phase(250);
    write_limit(11'h7FF & 11'd768);
    random_phase(250);

    settle();
    if (errors == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end
endmodule
